// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, switched off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication on the same clock and reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ----- sv/lgge_pkg.sv -----
// Package: shared types and constants of the life grid engine.
`default_nettype none
package lgge_pkg;

  localparam int OP_W     = 2;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 7;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2
  } lgge_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_in;   // latch the incoming item
    logic cnt_clr;   // restart the row counter
    logic cnt_inc;   // advance the row counter
    logic clr_step;  // write a zero row at the counter address
    logic gen_step;  // one step of the generation sweep
    logic cell_wr;   // write back the modified row of a cell write
    logic put_out;   // load the output register from the read row
  } lgge_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    lgge_op_e op_in;    // op of the item on the input port
    lgge_op_e op_q;     // op of the latched item
    logic     clr_done; // counter at the last row of the clear sweep
    logic     gen_done; // counter at the last step of the generation
    logic     out_free; // output register can take a result this cycle
  } lgge_status_t;

endpackage
`default_nettype wire

// ----- sv/lgge_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none
module lgge_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// ----- sv/lgge_ctrl.sv -----
// Controller: state machine sequencing clear, cell access and generation sweeps.
`default_nettype none
module lgge_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lgge_pkg::lgge_status_t status_i,
  output lgge_pkg::lgge_cmd_t    cmd_o
);
  import lgge_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR   = 5'b00001,
    ST_IDLE    = 5'b00010,
    ST_ACC_RD  = 5'b00100,
    ST_ACC_DAT = 5'b01000,
    ST_GEN     = 5'b10000
  } lgge_state_e;

  lgge_state_e state_q, state_d;
  logic        accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        if (status_i.clr_done) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.take_in = 1'b1;
          case (status_i.op_in)
            OP_WRITE, OP_READ: state_d = ST_ACC_RD;
            OP_STEP:           state_d = ST_GEN;
            default:           state_d = ST_IDLE;  // unused op, dropped
          endcase
        end
      end
      ST_ACC_RD: begin
        state_d = ST_ACC_DAT;
      end
      ST_ACC_DAT: begin
        case (status_i.op_q)
          OP_WRITE: begin
            cmd_o.cell_wr = 1'b1;
            state_d       = ST_IDLE;
          end
          OP_READ: begin
            // hold the row read until the output register frees up
            if (status_i.out_free) begin
              cmd_o.put_out = 1'b1;
              state_d       = ST_IDLE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_GEN: begin
        cmd_o.gen_step = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        if (status_i.gen_done) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/lgge_dp.sv -----
// Datapath: grid memory, row window, neighbor count and output register.
`default_nettype none
module lgge_dp #(
  parameter int GRID_WIDTH  = 128,
  parameter int GRID_HEIGHT = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lgge_pkg::lgge_cmd_t         cmd_i,
  output lgge_pkg::lgge_status_t      status_o,
  input  logic [lgge_pkg::OP_W-1:0]   op_i,
  input  logic [lgge_pkg::ROW_W-1:0]  row_i,
  input  logic [lgge_pkg::COL_W-1:0]  col_i,
  input  logic                        cell_in_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        cell_out_o,
  output logic [lgge_pkg::ROW_W-1:0]  row_out_o,
  output logic [lgge_pkg::COL_W-1:0]  col_out_o
);
  import lgge_pkg::*;

  localparam int AW  = $clog2(GRID_HEIGHT);
  localparam int CW  = $clog2(GRID_HEIGHT + 3);
  localparam int XW  = $clog2(GRID_WIDTH);
  localparam int RIW = (AW > ROW_W) ? AW : ROW_W;
  localparam int CIW = (XW > COL_W) ? XW : COL_W;
  localparam int SurviveN = 2;
  localparam int BirthN   = 3;

  // latched item
  lgge_op_e          op_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic              cell_q;

  logic [CW-1:0]     cnt_q;
  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     cnt_m3;

  logic [GRID_WIDTH-1:0] above_q, here_q, first_q;
  logic [GRID_WIDTH-1:0] below, new_row, mod_row, rd_data;

  logic              wr_en;
  logic [AW-1:0]     wr_addr, rd_addr, row_idx;
  logic [GRID_WIDTH-1:0] wr_data;
  logic [RIW-1:0]    row_wide;
  logic [CIW-1:0]    col_wide;
  logic [XW-1:0]     col_idx;
  logic              in_grid, gen_wr;

  logic              out_valid_q;
  logic              cell_out_q;
  logic [ROW_W-1:0]  row_out_q;
  logic [COL_W-1:0]  col_out_q;

  assign row_wide = RIW'(row_q);
  assign col_wide = CIW'(col_q);
  assign row_idx  = row_wide[AW-1:0];
  assign col_idx  = col_wide[XW-1:0];
  assign in_grid  = (32'(row_q) < 32'(GRID_HEIGHT)) && (32'(col_q) < 32'(GRID_WIDTH));

  // Sweep order: step 0 reads the last row, step k reads row k-1; data lands at the
  // next step. From step 3 on, row (step-3) is computed and written back.
  assign cnt_m1 = cnt_q - CW'(1);
  assign cnt_m3 = cnt_q - CW'(3);
  assign gen_wr = (cnt_q >= CW'(3));
  assign below  = (cnt_q == CW'(GRID_HEIGHT + 2)) ? first_q : rd_data;

  for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_col
    localparam int L = (c == 0) ? GRID_WIDTH - 1 : c - 1;
    localparam int R = (c == GRID_WIDTH - 1) ? 0 : c + 1;
    logic [3:0] nbr;
    assign nbr = 4'(above_q[L]) + 4'(above_q[c]) + 4'(above_q[R])
               + 4'(here_q[L]) + 4'(here_q[R])
               + 4'(below[L]) + 4'(below[c]) + 4'(below[R]);
    assign new_row[c] = (nbr == 4'(BirthN)) || (here_q[c] && (nbr == 4'(SurviveN)));
  end

  always_comb begin
    mod_row          = rd_data;
    mod_row[col_idx] = cell_q;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (cmd_i.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q[AW-1:0];
    end else if (cmd_i.gen_step && gen_wr) begin
      wr_en   = 1'b1;
      wr_addr = cnt_m3[AW-1:0];
      wr_data = new_row;
    end else if (cmd_i.cell_wr && in_grid) begin
      wr_en   = 1'b1;
      wr_addr = row_idx;
      wr_data = mod_row;
    end
  end

  assign rd_addr = !cmd_i.gen_step  ? row_idx :
                   (cnt_q == '0)    ? AW'(GRID_HEIGHT - 1) : cnt_m1[AW-1:0];

  lgge_ram #(
    .WIDTH (GRID_WIDTH),
    .DEPTH (GRID_HEIGHT)
  ) u_grid_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      op_q   <= lgge_op_e'(op_i);
      row_q  <= row_i;
      col_q  <= col_i;
      cell_q <= cell_in_i;
    end
    if (cmd_i.gen_step) begin
      if (cnt_q == CW'(1)) begin
        above_q <= rd_data;
      end else if (cnt_q == CW'(2)) begin
        here_q  <= rd_data;
        first_q <= rd_data;
      end else if (gen_wr) begin
        above_q <= here_q;
        here_q  <= rd_data;
      end
    end
    if (cmd_i.put_out) begin
      cell_out_q <= in_grid ? rd_data[col_idx] : 1'b0;
      row_out_q  <= row_q;
      col_out_q  <= col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.put_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.op_in    = lgge_op_e'(op_i);
  assign status_o.op_q     = op_q;
  assign status_o.clr_done = (cnt_q == CW'(GRID_HEIGHT - 1));
  assign status_o.gen_done = (cnt_q == CW'(GRID_HEIGHT + 2));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign cell_out_o  = cell_out_q;
  assign row_out_o   = row_out_q;
  assign col_out_o   = col_out_q;

endmodule
`default_nettype wire

// ----- sv/life_grid_generation_engine_core.sv -----
// Top level: toroidal B3/S23 life engine on a GRID_WIDTH x GRID_HEIGHT grid.
// Cell write: row read in ACC_RD, modified and written back in ACC_DAT; then ready for the next item.
// Cell read: row read in ACC_RD, result loaded from ACC_DAT and held until taken; ACC_DAT
//   waits while a stalled result still holds the output register; then ready for the next item.
// Generation: one sweep over the grid, one row per cycle; the input is ready again after it.
// Reset: a clearing pass writes GRID_HEIGHT zero rows, one per cycle; s_axis_tready_o is low.
`default_nettype none
module life_grid_generation_engine_core #(
  parameter int GRID_WIDTH  = 128,
  parameter int GRID_HEIGHT = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input stream
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [1:0] op, [7:2] row, [14:8] col, [15] cell_in
  input  logic [lgge_pkg::IN_TDATA_W-1:0]       s_axis_tdata_i,
  // result stream
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // [0] cell_out, [6:1] row_out, [13:7] col_out, [15:14] zero
  output logic [lgge_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o
);
  import lgge_pkg::*;

  lgge_cmd_t    cmd;
  lgge_status_t status;

  logic [OP_W-1:0]  in_op;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic             in_cell;
  logic             cell_out;
  logic [ROW_W-1:0] row_out;
  logic [COL_W-1:0] col_out;

  // unpack the input transfer, lowest field first
  assign in_op   = s_axis_tdata_i[OP_W-1:0];
  assign in_row  = s_axis_tdata_i[OP_W+ROW_W-1:OP_W];
  assign in_col  = s_axis_tdata_i[OP_W+ROW_W+COL_W-1:OP_W+ROW_W];
  assign in_cell = s_axis_tdata_i[OP_W+ROW_W+COL_W];

  // controller owns the handshake on the input side
  lgge_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath holds the grid RAM, the three-row window and the result register
  lgge_dp #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .op_i        (in_op),
    .row_i       (in_row),
    .col_i       (in_col),
    .cell_in_i   (in_cell),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .cell_out_o  (cell_out),
    .row_out_o   (row_out),
    .col_out_o   (col_out)
  );

  // pack the result, zero fill to a whole number of bytes
  assign m_axis_tdata_o = {(OUT_TDATA_W - 1 - ROW_W - COL_W)'(0), col_out, row_out, cell_out};

endmodule
`default_nettype wire

// ----- sv/lgge_checker.sv -----
// Port-level checker of the life grid engine and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module lgge_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_tvalid_i,
  input logic                               s_tready_i,
  input logic [lgge_pkg::IN_TDATA_W-1:0]    s_tdata_i,
  input logic                               m_tvalid_i,
  input logic                               m_tready_i,
  input logic [lgge_pkg::OUT_TDATA_W-1:0]   m_tdata_i
);
  import lgge_pkg::*;

  logic s_xfer;
  logic op_read;
  logic op_known;

  assign s_xfer   = s_tvalid_i && s_tready_i;
  assign op_read  = (s_tdata_i[OP_W-1:0] == OP_READ);
  assign op_known = (s_tdata_i[OP_W-1:0] == OP_READ) || (s_tdata_i[OP_W-1:0] == OP_WRITE)
                 || (s_tdata_i[OP_W-1:0] == OP_STEP);

  // a known op keeps the engine busy for at least the next cycle
  `ASSERT_IMPL(a_busy_after_xfer, clk_i, rst_ni, s_xfer && op_known, ##1 !s_tready_i, "engine took back-to-back items")

  // a read into an empty output register yields a valid result after the ACC_RD and ACC_DAT states
  `ASSERT_IMPL(a_read_result, clk_i, rst_ni, s_xfer && op_read && !m_tvalid_i, ##3 m_tvalid_i, "read result missing")

  // writes, generation steps and dropped ops never produce a result
  `ASSERT_IMPL(a_no_spurious, clk_i, rst_ni, s_xfer && !op_read && !m_tvalid_i, ##1 !m_tvalid_i ##1 !m_tvalid_i ##1 !m_tvalid_i, "result without a read")

  // stalled result holds
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i, ##1 (m_tvalid_i && $stable(m_tdata_i)), "stalled result changed")

endmodule

bind life_grid_generation_engine_core lgge_checker u_lgge_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .s_tdata_i  (s_axis_tdata_i),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);
`default_nettype wire
